// File: src/ghau_pkg.sv
// Shared constants, codes and types for the generational handle allocator.
package ghau_pkg;

  localparam int SLOT_COUNT_DEF = 1024;

  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int GEN_W        = 16;
  localparam int SLOT_FIELD_W = 16;
  localparam int HANDLE_W     = GEN_W + SLOT_FIELD_W;
  localparam int LIVE_W       = 17;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  localparam logic [GEN_W-1:0] GEN_START = 16'd1;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic             live;
  } tbl_entry_t;

  localparam int TBL_W = GEN_W + 1;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

// File: src/ghau_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ghau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ghau_ctrl.sv
// Controller: request sequencing and output handshake.
module ghau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ghau_pkg::ctrl_cmd_t cmd_o
);
  import ghau_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit  = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_o.commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !cmd_o.commit)
    else $error("result overwritten while stalled");

  // every request reaches commit stage the cycle after capture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_EXEC))
    else $error("capture did not enter execute");

  // hold a stalled result until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

// File: src/ghau_datapath.sv
// Datapath: slot table, free stack, counters and result registers.
module ghau_datapath #(
  parameter int SLOT_COUNT = ghau_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ghau_pkg::ctrl_cmd_t           cmd_i,
  input  logic [ghau_pkg::CMD_W-1:0]    command_i,
  input  logic [ghau_pkg::HANDLE_W-1:0] handle_in_i,
  output logic [ghau_pkg::STATUS_W-1:0] status_o,
  output logic [ghau_pkg::HANDLE_W-1:0] handle_out_o,
  output logic [ghau_pkg::SLOT_FIELD_W-1:0] slot_index_o,
  output logic [ghau_pkg::LIVE_W-1:0]   live_total_o
);
  import ghau_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int STK_W  = GEN_W + SLOT_W;

  logic [CMD_W-1:0]    cmd_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [CNT_W-1:0]    mark_q, mark_d;
  logic [CNT_W-1:0]    depth_q, depth_d;
  logic [CNT_W-1:0]    live_q, live_d;

  logic [STATUS_W-1:0]     status_q, status_d;
  logic [HANDLE_W-1:0]     hout_q, hout_d;
  logic [SLOT_FIELD_W-1:0] sidx_q, sidx_d;
  logic [LIVE_W-1:0]       livet_q;

  logic             tbl_we;
  logic [SLOT_W-1:0] tbl_waddr;
  tbl_entry_t       tbl_wdata;
  logic [TBL_W-1:0] tbl_rdata;
  tbl_entry_t       tbl_rd;

  logic             stk_we;
  logic [SLOT_W-1:0] stk_raddr;
  logic [STK_W-1:0] stk_wdata;
  logic [STK_W-1:0] stk_rd;

  logic [SLOT_W-1:0] h_slot;
  logic              in_range;
  logic              hit;
  logic [GEN_W-1:0]  gen_inc;
  logic [GEN_W-1:0]  gen_next;
  logic              alloc_ok;
  logic              from_stack;
  logic [SLOT_W-1:0] alloc_slot;
  logic [GEN_W-1:0]  alloc_gen;

  // slot table: reads of entries at or above the high-water mark are masked
  // off by the range check, so they need no clearing after reset
  ghau_ram #(.WIDTH(TBL_W), .DEPTH(SLOT_COUNT)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (handle_in_i[SLOT_W-1:0]),
    .rdata_o (tbl_rdata)
  );

  // free stack holds {next generation, slot}, i.e. the handle to reissue
  ghau_ram #(.WIDTH(STK_W), .DEPTH(SLOT_COUNT)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q[SLOT_W-1:0]),
    .wdata_i (stk_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  assign stk_raddr = SLOT_W'(depth_q - CNT_W'(1));
  assign tbl_rd    = tbl_entry_t'(tbl_rdata);

  always_comb begin
    h_slot   = handle_q[SLOT_W-1:0];
    in_range = {1'b0, handle_q[SLOT_FIELD_W-1:0]} < LIVE_W'(mark_q);
    hit      = in_range && tbl_rd.live &&
               (tbl_rd.gen == handle_q[HANDLE_W-1:SLOT_FIELD_W]);
    gen_inc  = tbl_rd.gen + GEN_W'(1);
    gen_next = (gen_inc == '0) ? GEN_START : gen_inc;

    from_stack = (depth_q != '0);
    alloc_ok   = from_stack || (mark_q < CNT_W'(SLOT_COUNT));
    alloc_slot = from_stack ? stk_rd[SLOT_W-1:0] : mark_q[SLOT_W-1:0];
    alloc_gen  = from_stack ? stk_rd[STK_W-1:SLOT_W] : GEN_START;
  end

  always_comb begin
    status_d  = ST_INVALID;
    hout_d    = '0;
    sidx_d    = '0;
    mark_d    = mark_q;
    depth_d   = depth_q;
    live_d    = live_q;
    tbl_we    = 1'b0;
    tbl_waddr = h_slot;
    tbl_wdata = '{gen: gen_next, live: 1'b0};
    stk_we    = 1'b0;
    stk_wdata = {gen_next, h_slot};
    case (cmd_q)
      CMD_ALLOC: begin
        if (alloc_ok) begin
          status_d  = ST_OK;
          hout_d    = {alloc_gen, SLOT_FIELD_W'(alloc_slot)};
          sidx_d    = SLOT_FIELD_W'(alloc_slot);
          live_d    = live_q + CNT_W'(1);
          tbl_we    = 1'b1;
          tbl_waddr = alloc_slot;
          tbl_wdata = '{gen: alloc_gen, live: 1'b1};
          if (from_stack) begin
            depth_d = depth_q - CNT_W'(1);
          end else begin
            mark_d = mark_q + CNT_W'(1);
          end
        end else begin
          status_d = ST_FULL;
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          status_d = ST_OK;
          sidx_d   = SLOT_FIELD_W'(h_slot);
        end
      end
      CMD_FREE: begin
        if (hit) begin
          status_d = ST_OK;
          sidx_d   = SLOT_FIELD_W'(h_slot);
          tbl_we   = 1'b1;
          stk_we   = 1'b1;
          depth_d  = depth_q + CNT_W'(1);
          live_d   = live_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
    tbl_we = tbl_we && cmd_i.commit;
    stk_we = stk_we && cmd_i.commit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      handle_q <= handle_in_i;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      hout_q   <= hout_d;
      sidx_q   <= sidx_d;
      livet_q  <= LIVE_W'(live_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q  <= '0;
      depth_q <= '0;
      live_q  <= '0;
    end else if (cmd_i.commit) begin
      mark_q  <= mark_d;
      depth_q <= depth_d;
      live_q  <= live_d;
    end
  end

  assign status_o     = status_q;
  assign handle_out_o = hout_q;
  assign slot_index_o = sidx_q;
  assign live_total_o = livet_q;

  // every slot below the mark is either live or on the free stack, once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W+1)'(live_q) + (CNT_W+1)'(depth_q) == (CNT_W+1)'(mark_q))
    else $error("live count and free stack disagree with mark");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= CNT_W'(SLOT_COUNT))
    else $error("high-water mark beyond slot count");

  // a lookup leaves all bookkeeping untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && (cmd_q == CMD_LOOKUP) |=>
      $stable(mark_q) && $stable(depth_q) && $stable(live_q))
    else $error("lookup changed allocator state");

  // nothing is written to the slot table or the free stack outside commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_we || stk_we) |-> cmd_i.commit)
    else $error("memory write outside commit");

endmodule

// File: src/generational_handle_allocator_unit.sv
// Generational handle allocator: top level joining controller and datapath.
// A request is captured (slot table and free stack read), then committed
// (update and write-back, output register loaded); the commit waits while a
// result is stalled. A new request is accepted only after the previous one
// commits, so a stalled result holds the unit.
// Reset clears counters and control only; no clearing pass is needed since
// slots at or above the high-water mark are treated as fresh (generation 1).
module generational_handle_allocator_unit #(
  parameter int SLOT_COUNT = ghau_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ghau_pkg::CMD_W-1:0]        command_i,
  input  logic [ghau_pkg::HANDLE_W-1:0]     handle_in_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ghau_pkg::STATUS_W-1:0]     status_o,
  output logic [ghau_pkg::HANDLE_W-1:0]     handle_out_o,
  output logic [ghau_pkg::SLOT_FIELD_W-1:0] slot_index_o,
  output logic [ghau_pkg::LIVE_W-1:0]       live_total_o
);
  import ghau_pkg::*;

  // capture: latch the request and launch both RAM reads
  // commit: resolve the request, write back, load the result register
  ctrl_cmd_t ctrl_cmd;

  ghau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctrl_cmd)
  );

  // datapath keeps the slot table, the free stack of reusable handles,
  // the high-water mark, the free stack depth and the live count
  ghau_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .command_i    (command_i),
    .handle_in_i  (handle_in_i),
    .status_o     (status_o),
    .handle_out_o (handle_out_o),
    .slot_index_o (slot_index_o),
    .live_total_o (live_total_o)
  );

endmodule
